// File: hdl/b32dec_pkg.sv
// Shared types and constants for the base32 stream decoder.
// No dependencies; every module of the decoder imports this package.
`timescale 1ns / 1ps
`default_nettype none

package b32dec_pkg;

  // One input item: a character of the encoded text.
  typedef struct packed {
    logic [7:0] char_code;
    logic       end_of_string;
  } char_item_t;

  // One result item.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_valid;
    logic       string_done;
    logic       bad_character;
  } result_item_t;

  // Character classes.
  typedef enum logic [1:0] {
    CLS_SYMBOL = 2'd0,
    CLS_SKIP   = 2'd1,
    CLS_NUL    = 2'd2,
    CLS_BAD    = 2'd3
  } char_class_t;

  // Classified character.
  typedef struct packed {
    char_class_t cls;
    logic [4:0]  value;
  } symbol_t;

  localparam int unsigned SYM_BITS  = 5;
  localparam int unsigned ACC_BITS  = 12;
  localparam int unsigned CNT_BITS  = 3;

  localparam logic [4:0] SYM_MASK       = 5'h1F;
  localparam logic [4:0] LETTER_OFFSET  = 5'd1;   // 'A' -> 0
  localparam logic [4:0] DIGIT_OFFSET   = 5'd8;   // '2' -> 26 (low bits of '2' are 18)

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_HYPHEN = 8'h2D;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_ONE    = 8'h31;
  localparam logic [7:0] CH_TWO    = 8'h32;
  localparam logic [7:0] CH_SEVEN  = 8'h37;
  localparam logic [7:0] CH_EIGHT  = 8'h38;
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_UPPER_B = 8'h42;
  localparam logic [7:0] CH_UPPER_L = 8'h4C;
  localparam logic [7:0] CH_UPPER_O = 8'h4F;
  localparam logic [7:0] CH_UPPER_Z = 8'h5A;
  localparam logic [7:0] CH_LOWER_A = 8'h61;
  localparam logic [7:0] CH_LOWER_Z = 8'h7A;

endpackage : b32dec_pkg

`default_nettype wire

// File: hdl/b32dec_symbol.sv
// Character classifier: maps one text character to a base32 symbol value,
// a skip, a string terminator or an error. Depends on b32dec_pkg.
`timescale 1ns / 1ps
`default_nettype none

module b32dec_symbol (
  input  wire logic [7:0]          char_code,
  output b32dec_pkg::symbol_t      sym
);
  import b32dec_pkg::*;

  logic [7:0] mapped;

  // Read the look-alike digits as letters.
  always_comb begin
    case (char_code)
      CH_ZERO:  mapped = CH_UPPER_O;
      CH_ONE:   mapped = CH_UPPER_L;
      CH_EIGHT: mapped = CH_UPPER_B;
      default:  mapped = char_code;
    endcase
  end

  always_comb begin
    sym.cls   = CLS_BAD;
    sym.value = '0;
    if (mapped inside {[CH_UPPER_A:CH_UPPER_Z], [CH_LOWER_A:CH_LOWER_Z]}) begin
      sym.cls   = CLS_SYMBOL;
      sym.value = (mapped[4:0] & SYM_MASK) - LETTER_OFFSET;
    end else if (mapped inside {[CH_TWO:CH_SEVEN]}) begin
      sym.cls   = CLS_SYMBOL;
      sym.value = mapped[4:0] + DIGIT_OFFSET;
    end else if (mapped == CH_NUL) begin
      sym.cls   = CLS_NUL;
    end else if (mapped inside {CH_SPACE, CH_TAB, CH_CR, CH_LF, CH_HYPHEN}) begin
      sym.cls   = CLS_SKIP;
    end
  end

endmodule : b32dec_symbol

`default_nettype wire

// File: hdl/b32dec_core.sv
// Decoder state and result logic: bit accumulator, pending bit count and
// sticky flags, updated once per processed item. Depends on b32dec_pkg.
`timescale 1ns / 1ps
`default_nettype none

module b32dec_core (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      fire,
  input  wire b32dec_pkg::char_item_t    item,
  input  wire b32dec_pkg::symbol_t       sym,
  output b32dec_pkg::result_item_t       result,
  output logic                           result_valid
);
  import b32dec_pkg::*;

  logic [ACC_BITS-1:0] accumulator, accumulator_next;
  logic [CNT_BITS-1:0] pending, pending_next;
  logic                error_seen, error_seen_next;
  logic                string_ended, string_ended_next;

  logic                active;
  logic [CNT_BITS:0]   bit_sum;
  logic [ACC_BITS-1:0] acc_shifted;
  logic                have_byte;
  logic [7:0]          byte_out;

  always_comb begin
    active            = !string_ended && !error_seen;
    bit_sum           = {1'b0, pending} + (CNT_BITS+1)'(SYM_BITS);
    acc_shifted       = {accumulator[ACC_BITS-SYM_BITS-1:0], sym.value};
    have_byte         = 1'b0;
    byte_out          = '0;
    accumulator_next  = accumulator;
    pending_next      = pending;
    error_seen_next   = error_seen;
    string_ended_next = string_ended;

    if (active) begin
      case (sym.cls)
        CLS_NUL:    string_ended_next = 1'b1;
        CLS_BAD:    error_seen_next   = 1'b1;
        CLS_SYMBOL: begin
          accumulator_next = acc_shifted;
          // Low three bits of the sum are the leftover count either way.
          pending_next     = bit_sum[CNT_BITS-1:0];
          if (bit_sum[CNT_BITS]) begin
            have_byte = 1'b1;
            byte_out  = 8'(acc_shifted >> bit_sum[CNT_BITS-1:0]);
          end
        end
        default: ;
      endcase
    end

    result.data_byte     = byte_out;
    result.byte_valid    = have_byte;
    result.string_done   = item.end_of_string;
    result.bad_character = error_seen_next;
    result_valid         = have_byte || item.end_of_string;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      accumulator  <= '0;
      pending      <= '0;
      error_seen   <= 1'b0;
      string_ended <= 1'b0;
    end else if (fire) begin
      if (item.end_of_string) begin
        // Drop leftover bits and clear for the next string.
        accumulator  <= '0;
        pending      <= '0;
        error_seen   <= 1'b0;
        string_ended <= 1'b0;
      end else begin
        accumulator  <= accumulator_next;
        pending      <= pending_next;
        error_seen   <= error_seen_next;
        string_ended <= string_ended_next;
      end
    end
  end

endmodule : b32dec_core

`default_nettype wire

// File: hdl/base32_stream_decoder_top.sv
// Base32 stream decoder, top level: one character item in, at most one
// result item out. An item passes through the input register, then the
// result register, from which the sink takes it.
// Throughput: one item per cycle while the sink does not stall; the state
// update in b32dec_core closes the loop. Reset (rst, synchronous) empties
// both registers and clears the decoder state.
`timescale 1ns / 1ps
`default_nettype none

module base32_stream_decoder_top (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      src_valid,
  output logic                           src_stall,
  input  wire b32dec_pkg::char_item_t    src_item,
  output logic                           res_valid,
  input  wire logic                      res_stall,
  output b32dec_pkg::result_item_t       res_item
);
  import b32dec_pkg::*;

  // Input register stage.
  logic         item_q_valid;
  char_item_t   item_q;

  // Processing handshake between the stages.
  logic         out_free;
  logic         fire;

  symbol_t      sym;
  result_item_t result;
  logic         result_valid;

  // The result register can take a new value when it is empty or being read.
  assign out_free  = !res_valid || !res_stall;
  // Process the held item whenever the result register can take its outcome.
  assign fire      = item_q_valid && out_free;
  // Hold the source off only while the held item cannot advance.
  assign src_stall = item_q_valid && !out_free;

  // Input register: load a new item whenever the slot empties or advances.
  always_ff @(posedge clk) begin
    if (rst) begin
      item_q_valid <= 1'b0;
    end else if (!src_stall) begin
      item_q_valid <= src_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (src_valid && !src_stall) begin
      item_q <= src_item;
    end
  end

  b32dec_symbol u_symbol (
    .char_code (item_q.char_code),
    .sym       (sym)
  );

  b32dec_core u_core (
    .clk          (clk),
    .rst          (rst),
    .fire         (fire),
    .item         (item_q),
    .sym          (sym),
    .result       (result),
    .result_valid (result_valid)
  );

  // Result register: advance when free; items without a result (skips, symbols that
  // finish no byte, characters at or after an error or terminator) leave it empty.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (out_free) begin
      res_valid <= fire && result_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && fire && result_valid) begin
      res_item <= result;
    end
  end

  // A result that does not close a string always carries a byte.
  assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_item.string_done |-> res_item.byte_valid)
    else $error("result without byte and without string end");

  // A result without a byte carries a zero data byte.
  assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_item.byte_valid |-> res_item.data_byte == 8'h00)
    else $error("nonzero data byte on a byte-less result");

  // The source is held off only while an item waits in the input register.
  assert property (@(posedge clk) disable iff (rst)
    src_stall |-> item_q_valid && res_valid && res_stall)
    else $error("source stalled without a blocked item");

  // An item that is processed while the result register is blocked is a slip.
  assert property (@(posedge clk) disable iff (rst)
    fire |-> !(res_valid && res_stall))
    else $error("item processed into a blocked result register");

endmodule : base32_stream_decoder_top

`default_nettype wire
